// ===== rtl/srt_pkg.sv =====
// Shared types, codes and widths for the sorted record table.
`default_nettype none
package srt_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int TDATA_W   = 56;
    localparam int NAME_W    = 3;
    localparam int AGE_W     = 7;
    localparam int IDENT_W   = 14;
    localparam int CENTS_W   = 20;
    localparam int KEY_W     = 5;
    localparam int POS_W     = 4;
    localparam int FILL_W    = 5;
    localparam int STATUS_W  = 2;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [CENTS_W-1:0] cents;
        logic [IDENT_W-1:0] ident;
        logic [AGE_W-1:0]   age;
        logic [NAME_W-1:0]  name;
    } rec_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/srt_ctrl.sv =====
// Controller state machine for the sorted record table.
`default_nettype none
module srt_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output srt_pkg::ctrl_cmd_t      cmd
);

    srt_pkg::state_t state_reg;
    srt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srt_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srt_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = srt_pkg::S_EXEC;
                end
            end
            srt_pkg::S_EXEC: begin
                state_next = srt_pkg::S_RESP;
            end
            srt_pkg::S_RESP: begin
                if (m_tready) begin
                    state_next = s_tvalid ? srt_pkg::S_EXEC : srt_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = srt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            srt_pkg::S_IDLE: begin
                s_tready = 1'b1;
            end
            srt_pkg::S_EXEC: begin
                cmd.execute = 1'b1;
            end
            srt_pkg::S_RESP: begin
                m_tvalid = 1'b1;
                s_tready = m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
        cmd.capture = s_tvalid && s_tready;
    end

endmodule
`default_nettype wire

// ===== rtl/srt_dp.sv =====
// Datapath of the sorted record table: entry cells, count and result register.
`default_nettype none
module srt_dp #(
    parameter int DEPTH = srt_pkg::DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire srt_pkg::ctrl_cmd_t           cmd,
    input  wire logic [srt_pkg::TDATA_W-1:0]  s_tdata,
    input  wire logic                         s_tuser,
    output logic      [srt_pkg::TDATA_W-1:0]  m_tdata,
    output logic      [srt_pkg::STATUS_W-1:0] m_tuser
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    srt_pkg::cmd_t               cmd_reg;
    srt_pkg::rec_t               rec_reg;
    logic [srt_pkg::POS_W-1:0]   pos_reg;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    srt_pkg::rec_t               cell_reg  [DEPTH];
    srt_pkg::rec_t               cell_next [DEPTH];
    logic [DEPTH-1:0]            lt;
    logic                        full;
    logic                        empty;
    logic                        pos_past;
    logic [IW-1:0]               sel_idx;
    srt_pkg::rec_t               sel_rec;
    srt_pkg::rec_t               out_rec_reg;
    srt_pkg::rec_t               out_rec_next;
    srt_pkg::status_t            out_st_reg;
    srt_pkg::status_t            out_st_next;
    logic [srt_pkg::FILL_W-1:0]  out_fill_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pos_past = (CW + srt_pkg::POS_W)'(pos_reg) >= (CW + srt_pkg::POS_W)'(count_reg);
    assign sel_idx  = pos_past ? IW'(count_reg - CW'(1)) : IW'(pos_reg);
    assign sel_rec  = cell_reg[sel_idx];

    // hold request fields
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg <= srt_pkg::cmd_t'(s_tuser);
            rec_reg <= srt_pkg::rec_t'(s_tdata[srt_pkg::KEY_W + srt_pkg::CENTS_W
                        + srt_pkg::IDENT_W + srt_pkg::AGE_W + srt_pkg::NAME_W - 1:0]);
            pos_reg <= s_tdata[52:49];
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            assign lt[i] = (CW'(i) < count_reg) && (cell_reg[i].key < rec_reg.key);

            always_comb begin
                cell_next[i] = cell_reg[i];
                if (cmd_reg == srt_pkg::CMD_INSERT) begin
                    if (!full && !lt[i]) begin
                        if (i == 0) begin
                            cell_next[i] = rec_reg;
                        end else if (lt[(i > 0) ? i - 1 : 0]) begin
                            cell_next[i] = rec_reg;
                        end else begin
                            cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                        end
                    end
                end else begin
                    if (!empty && (i < DEPTH - 1) && (CW'(i) >= CW'(sel_idx))) begin
                        cell_next[i] = cell_reg[(i < DEPTH - 1) ? i + 1 : i];
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (cmd.execute) begin
                    cell_reg[i] <= cell_next[i];
                end
            end
        end
    endgenerate

    always_comb begin
        count_next   = count_reg;
        out_rec_next = '0;
        out_st_next  = srt_pkg::ST_DONE;
        case (cmd_reg)
            srt_pkg::CMD_INSERT: begin
                if (full) begin
                    out_st_next = srt_pkg::ST_FULL;
                end else begin
                    count_next = CW'(count_reg + CW'(1));
                end
            end
            srt_pkg::CMD_REMOVE: begin
                if (empty) begin
                    out_st_next = srt_pkg::ST_EMPTY;
                end else begin
                    out_rec_next = sel_rec;
                    count_next   = CW'(count_reg - CW'(1));
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.execute) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            out_rec_reg  <= out_rec_next;
            out_st_reg   <= out_st_next;
            out_fill_reg <= srt_pkg::FILL_W'(count_next);
        end
    end

    assign m_tdata = {2'b00, out_fill_reg, out_rec_reg.key, out_rec_reg.cents,
                      out_rec_reg.ident, out_rec_reg.age, out_rec_reg.name};
    assign m_tuser = out_st_reg;

endmodule
`default_nettype wire

// ===== rtl/sorted_record_table.sv =====
// Top level of the sorted record table.
//
//  group  dir  payload
//  s_*    in   tuser: cmd | tdata: name, age, ident, cents, key, position
//  m_*    out  tuser: status | tdata: name, age, ident, cents, key, fill
//
//  Each request is latched first; then every cell compares its key and
//  shifts in parallel, and the result register then holds the outcome.
//  A new request is taken in the cycle the result is taken, so the table
//  never takes a new request before the last result has been taken.
//  Reset clears the entry count and the controller; entry cells need none.
//  A stalled result blocks the next request from executing.
`default_nettype none
module sorted_record_table #(
    parameter int DEPTH = srt_pkg::DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // [2:0] name, [9:3] age, [23:10] ident, [43:24] cents, [48:44] key, [52:49] position
    input  wire logic [srt_pkg::TDATA_W-1:0]  s_tdata,
    // [0] cmd
    input  wire logic                         s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [2:0] name, [9:3] age, [23:10] ident, [43:24] cents, [48:44] key, [53:49] fill
    output logic      [srt_pkg::TDATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic      [srt_pkg::STATUS_W-1:0] m_tuser
);

    srt_pkg::ctrl_cmd_t cmd;

    srt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    srt_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule
`default_nettype wire

// ===== rtl/srt_chk.sv =====
// Port checker for the sorted record table and its bind.
`default_nettype none
module srt_chk #(
    parameter int DEPTH = srt_pkg::DEPTH_DEF
) (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [srt_pkg::TDATA_W-1:0]  m_tdata,
    input wire logic [srt_pkg::STATUS_W-1:0] m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == srt_pkg::STATUS_W'(srt_pkg::ST_FULL))
        |-> (m_tdata[53:49] == srt_pkg::FILL_W'(DEPTH)) && (m_tdata[48:0] == '0))
        else $error("dropped insert with table not full");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == srt_pkg::STATUS_W'(srt_pkg::ST_EMPTY))
        |-> (m_tdata == '0))
        else $error("empty remove returned data");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid ##1 m_tvalid)
        else $error("result not shown two cycles after request");

endmodule

bind sorted_record_table srt_chk #(.DEPTH(DEPTH)) u_srt_chk (.*);
`default_nettype wire

// ===== bench/sorted_record_table_test.sv =====
// Self-checking testbench for the sorted record table: directed table, then random requests.
`default_nettype none
module sorted_record_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = srt_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1630;
    localparam int IDLE_PCT     = 31;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        srt_pkg::cmd_t             cmd;
        srt_pkg::rec_t             rec;
        logic [srt_pkg::POS_W-1:0] pos;
    } request_t;

    typedef struct {
        srt_pkg::rec_t              rec;
        srt_pkg::status_t           status;
        logic [srt_pkg::FILL_W-1:0] fill;
    } outcome_t;

    typedef struct {
        request_t req;
        bit       typed;
        outcome_t want;
    } plan_row_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [srt_pkg::TDATA_W-1:0]    s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [srt_pkg::TDATA_W-1:0]    m_tdata;
    logic [srt_pkg::STATUS_W-1:0]   m_tuser;

    srt_pkg::rec_t         shadow_rec [DEPTH];
    int unsigned           shadow_count;
    outcome_t              pending_results [$];
    plan_row_t             plan [$];

    bit                    steady;
    bit                    hold_req;
    int                    hold_left;
    int unsigned           mismatches;
    int unsigned           n_insert, n_remove, n_full, n_empty, n_checked, peak_fill;

    sorted_record_table #(.DEPTH(DEPTH)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic outcome_t table_apply(request_t req);
        outcome_t    res;
        int unsigned slot;
        int unsigned idx;
        res.rec    = '0;
        res.status = srt_pkg::ST_DONE;
        if (req.cmd == srt_pkg::CMD_INSERT) begin
            n_insert++;
            if (shadow_count >= DEPTH) begin
                res.status = srt_pkg::ST_FULL;
                n_full++;
            end else begin
                slot = 0;
                while (slot < shadow_count && shadow_rec[slot].key < req.rec.key)
                    slot++;
                for (idx = shadow_count; idx > slot; idx--)
                    shadow_rec[idx] = shadow_rec[idx-1];
                shadow_rec[slot] = req.rec;
                shadow_count++;
            end
        end else begin
            n_remove++;
            if (shadow_count == 0) begin
                res.status = srt_pkg::ST_EMPTY;
                n_empty++;
            end else begin
                slot = 32'(req.pos);
                if (slot >= shadow_count)
                    slot = shadow_count - 1;
                res.rec = shadow_rec[slot];
                for (idx = slot; idx + 1 < shadow_count; idx++)
                    shadow_rec[idx] = shadow_rec[idx+1];
                shadow_count--;
            end
        end
        if (shadow_count > peak_fill)
            peak_fill = shadow_count;
        res.fill = shadow_count[srt_pkg::FILL_W-1:0];
        return res;
    endfunction

    function automatic plan_row_t mk_row(srt_pkg::cmd_t c, int unsigned name,
                                         int unsigned age, int unsigned ident,
                                         int unsigned cents, int unsigned key,
                                         int unsigned pos, bit typed,
                                         srt_pkg::status_t st, int unsigned fill);
        plan_row_t row;
        row.req.cmd        = c;
        row.req.rec.name   = name[srt_pkg::NAME_W-1:0];
        row.req.rec.age    = age[srt_pkg::AGE_W-1:0];
        row.req.rec.ident  = ident[srt_pkg::IDENT_W-1:0];
        row.req.rec.cents  = cents[srt_pkg::CENTS_W-1:0];
        row.req.rec.key    = key[srt_pkg::KEY_W-1:0];
        row.req.pos        = pos[srt_pkg::POS_W-1:0];
        row.typed          = typed;
        row.want.rec       = '0;
        row.want.status    = st;
        row.want.fill      = fill[srt_pkg::FILL_W-1:0];
        return row;
    endfunction

    task automatic send_request(request_t req, bit typed, outcome_t want);
        outcome_t got;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(srt_pkg::TDATA_W-srt_pkg::POS_W-$bits(srt_pkg::rec_t)){1'b0}},
                     req.pos, req.rec};
        s_tuser  <= req.cmd;
        do @(posedge aclk); while (!s_tready);
        got = table_apply(req);
        pending_results.push_back(typed ? want : got);
        @(negedge aclk);
    endtask

    task automatic check_field(string label, int unsigned want, int unsigned seen);
        if (want != seen) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, seen);
        end
    endtask

    // receiver side: random stalls, optional long hold
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual tdata=%h tuser=%0d",
                         $time, m_tdata, m_tuser);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                check_field("name",   32'(want.rec.name),  32'(m_tdata[2:0]));
                check_field("age",    32'(want.rec.age),   32'(m_tdata[9:3]));
                check_field("ident",  32'(want.rec.ident), 32'(m_tdata[23:10]));
                check_field("cents",  32'(want.rec.cents), 32'(m_tdata[43:24]));
                check_field("key",    32'(want.rec.key),   32'(m_tdata[48:44]));
                check_field("fill",   32'(want.fill),      32'(m_tdata[53:49]));
                check_field("status", 32'(want.status),    32'(m_tuser));
            end
        end
    end

    initial begin
        request_t    req;
        outcome_t    none;
        int unsigned insert_pct;
        int unsigned roll;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        steady       = 1'b0;
        hold_req     = 1'b0;
        shadow_count = 0;
        none         = '{rec: '0, status: srt_pkg::ST_DONE, fill: '0};
        mismatches   = 0;
        n_insert = 0; n_remove = 0; n_full = 0; n_empty = 0; n_checked = 0; peak_fill = 0;

        plan.push_back(mk_row(srt_pkg::CMD_REMOVE, 7, 99, 1234, 5678, 9, 0, 1,
                              srt_pkg::ST_EMPTY, 0));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 7, 127, 16383, 999999, 20, 15, 1,
                              srt_pkg::ST_DONE, 1));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 0, 0, 0, 0, 0, 0, 1,
                              srt_pkg::ST_DONE, 2));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 5, 64, 8192, 524288, 31, 9, 1,
                              srt_pkg::ST_DONE, 3));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 1, 1, 1, 1048575, 20, 3, 1,
                              srt_pkg::ST_DONE, 4));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 2, 33, 4242, 12345, 20, 6, 1,
                              srt_pkg::ST_DONE, 5));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 3, 40, 100, 250000, 10, 1, 1,
                              srt_pkg::ST_DONE, 6));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 4, 18, 9000, 777, 0, 2, 1,
                              srt_pkg::ST_DONE, 7));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 6, 90, 15000, 999998, 3, 4, 1,
                              srt_pkg::ST_DONE, 8));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 7, 21, 2048, 31415, 20, 5, 1,
                              srt_pkg::ST_DONE, 9));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 0, 55, 300, 4096, 15, 7, 1,
                              srt_pkg::ST_DONE, 10));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 1, 70, 12000, 65536, 1, 8, 1,
                              srt_pkg::ST_DONE, 11));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 2, 66, 7777, 100, 31, 10, 1,
                              srt_pkg::ST_DONE, 12));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 3, 12, 5555, 200, 7, 11, 1,
                              srt_pkg::ST_DONE, 13));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 4, 81, 3333, 300, 20, 12, 1,
                              srt_pkg::ST_DONE, 14));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 5, 44, 1111, 400, 0, 13, 1,
                              srt_pkg::ST_DONE, 15));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 6, 38, 2222, 500, 12, 14, 1,
                              srt_pkg::ST_DONE, 16));
        plan.push_back(mk_row(srt_pkg::CMD_INSERT, 7, 127, 16383, 1048575, 31, 15, 1,
                              srt_pkg::ST_FULL, 16));
        plan.push_back(mk_row(srt_pkg::CMD_REMOVE, 7, 127, 16383, 1048575, 31, 15, 0,
                              srt_pkg::ST_DONE, 0));
        plan.push_back(mk_row(srt_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0,
                              srt_pkg::ST_DONE, 0));
        plan.push_back(mk_row(srt_pkg::CMD_REMOVE, 3, 9, 77, 88, 4, 15, 0,
                              srt_pkg::ST_DONE, 0));
        plan.push_back(mk_row(srt_pkg::CMD_REMOVE, 1, 2, 3, 4, 5, 7, 0,
                              srt_pkg::ST_DONE, 0));
        plan.push_back(mk_row(srt_pkg::CMD_REMOVE, 6, 5, 4, 3, 2, 3, 0,
                              srt_pkg::ST_DONE, 0));
        plan.push_back(mk_row(srt_pkg::CMD_REMOVE, 2, 1, 0, 0, 0, 0, 0,
                              srt_pkg::ST_DONE, 0));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i])
            send_request(plan[i].req, plan[i].typed, plan[i].want);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ((i / 120) % 3)
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 55;
            endcase
            steady = (i >= 700 && i < 900);
            if (i == 300 || i == 1200)
                hold_req = 1'b1;
            req.cmd       = ($urandom_range(99) < insert_pct) ? srt_pkg::CMD_INSERT
                                                              : srt_pkg::CMD_REMOVE;
            req.rec.name  = srt_pkg::NAME_W'($urandom_range(7));
            req.rec.age   = srt_pkg::AGE_W'($urandom_range(127));
            req.rec.ident = srt_pkg::IDENT_W'($urandom_range(16383));
            req.rec.cents = srt_pkg::CENTS_W'(($urandom_range(9) == 0)
                                              ? $urandom_range(1048575)
                                              : $urandom_range(999999));
            roll = $urandom_range(99);
            if (roll < 50)
                req.rec.key = srt_pkg::KEY_W'($urandom_range(3));
            else if (roll < 95)
                req.rec.key = srt_pkg::KEY_W'($urandom_range(20));
            else
                req.rec.key = srt_pkg::KEY_W'($urandom_range(31, 21));
            if (shadow_count > 0 && $urandom_range(99) < 60)
                req.pos = srt_pkg::POS_W'($urandom_range(shadow_count - 1));
            else
                req.pos = srt_pkg::POS_W'($urandom_range(15));
            send_request(req, 1'b0, none);
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run: %0d inserts (%0d dropped on full), %0d removes (%0d on empty)",
                 n_insert, n_full, n_remove, n_empty);
        $display("Checked %0d results, peak fill %0d, %0d mismatches",
                 n_checked, peak_fill, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/srt_pkg.sv
rtl/srt_ctrl.sv
rtl/srt_dp.sv
rtl/sorted_record_table.sv
rtl/srt_chk.sv
bench/sorted_record_table_test.sv
